FILE: hdl/ihq_pkg.sv
// ihq_pkg: shared types and codes for the indexed min-heap queue
// used by ihq_cmp, indexed_min_heap_queue and ihq_chk; no dependencies
package ihq_pkg;

  localparam int DEF_MAX_NODES = 256;
  localparam int ID_SPACE      = 256;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [7:0]  node;
    logic [31:0] cost;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_UP, S_UP_CMP, S_DOWN, S_DN_L, S_DN_R, S_DN_CMP,
    S_PLACE, S_POP0, S_POP1, S_POP2, S_TOP, S_DONE
  } state_t;

endpackage

FILE: hdl/ihq_cmp.sv
// ihq_cmp: shared ordering unit, cost first and lower node id on ties
// depends on ihq_pkg
module ihq_cmp
  import ihq_pkg::*;
(
  input  entry_t a,
  input  entry_t b,
  output logic   a_first
);

  assign a_first = (a.cost != b.cost) ? (a.cost < b.cost) : (a.node < b.node);

endmodule

FILE: hdl/indexed_min_heap_queue.sv
// indexed_min_heap_queue: keyed min-priority queue on a binary heap with sequencer
// depends on ihq_pkg and ihq_cmp
//
//   channel | ports                                        | role
//   in      | in_valid in_ready in_kind in_node_id ...     | one request per transaction
//   out     | out_valid out_ready out_status ... out_entry_count | one result per request
//
// a query or rejected request goes from look straight to top and done; insert, change and pop
// add sift steps, with a parent read and a compare per level on sift up and child reads and
// a compare per level on sift down; the sequencer returns to idle after each result
// heap reads go through the single read port of the heap slot memory and one compare unit
// synchronous active-low reset clears the presence bits and the entry count, no clearing pass
// in_ready is high only in idle; a stalled result holds in the output register
module indexed_min_heap_queue
  import ihq_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  localparam int IW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_node_id,
  input  logic [31:0]   in_new_cost,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic          out_found,
  output logic [31:0]   out_queried_cost,
  output logic [7:0]    out_popped_node,
  output logic [31:0]   out_popped_cost,
  output logic          out_top_valid,
  output logic [7:0]    out_top_node,
  output logic [31:0]   out_top_cost,
  output logic [CW-1:0] out_entry_count
);

  localparam int LW = IW + 1;

  state_t state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    node_r, node_nxt;
  logic [31:0]   cost_r, cost_nxt;
  entry_t        mov_r, mov_nxt;
  entry_t        child_r, child_nxt;
  entry_t        pop_r, pop_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] sel_r, sel_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          chg_r, chg_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   qcost_r, qcost_nxt;

  logic          out_valid_r;
  logic [1:0]    o_status_r;
  logic          o_found_r;
  logic [31:0]   o_qcost_r;
  entry_t        o_pop_r;
  logic          o_tvalid_r;
  entry_t        o_top_r;
  logic [CW-1:0] o_cnt_r;

  entry_t        hs_mem [MAX_NODES];
  logic [31:0]   nc_mem [ID_SPACE];
  logic [IW-1:0] hp_mem [ID_SPACE];
  logic          pres_r [ID_SPACE];

  entry_t        hs_q;
  logic [31:0]   nc_q;
  logic [IW-1:0] hp_q;

  logic          hs_we, hs_re, nc_we, hp_we, pres_we, pres_wd, id_re;
  logic [IW-1:0] hs_wa, hs_ra, hp_wd;
  entry_t        hs_wd;
  logic [7:0]    nc_wa, hp_wa, pres_wa;
  logic [31:0]   nc_wd;

  entry_t        cmp_a, cmp_b;
  logic          a_first;

  logic          pres, full, out_free;
  logic [IW-1:0] par;
  logic [LW-1:0] lft, rgt, cnt_ext;

  assign pres     = pres_r[node_r];
  assign full     = cnt_r == CW'(MAX_NODES);
  assign par      = (idx_r - IW'(1)) >> 1;
  assign lft      = {idx_r, 1'b1};
  assign rgt      = lft + LW'(1);
  assign cnt_ext  = LW'(cnt_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;

  ihq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .a_first(a_first));

  always_comb begin
    case (state_r)
      S_UP_CMP: begin
        cmp_a = mov_r;
        cmp_b = hs_q;
      end
      S_DN_R: begin
        cmp_a = hs_q;
        cmp_b = child_r;
      end
      default: begin
        cmp_a = child_r;
        cmp_b = mov_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        case (kind_r)
          KIND_INSERT: state_nxt = (pres || full) ? S_TOP : S_UP;
          KIND_CHANGE: state_nxt = (!pres && full) ? S_TOP : S_UP;
          KIND_POP:    state_nxt = (cnt_r == '0) ? S_TOP : S_POP0;
          default:     state_nxt = S_TOP;
        endcase
      end
      S_UP: begin
        if (idx_r != '0) state_nxt = S_UP_CMP;
        else state_nxt = chg_r ? S_DOWN : S_PLACE;
      end
      S_UP_CMP: begin
        if (a_first) state_nxt = S_UP;
        else state_nxt = chg_r ? S_DOWN : S_PLACE;
      end
      S_DOWN:   state_nxt = (lft >= cnt_ext) ? S_PLACE : S_DN_L;
      S_DN_L:   state_nxt = (rgt < cnt_ext) ? S_DN_R : S_DN_CMP;
      S_DN_R:   state_nxt = S_DN_CMP;
      S_DN_CMP: state_nxt = a_first ? S_DOWN : S_PLACE;
      S_PLACE:  state_nxt = S_TOP;
      S_POP0:   state_nxt = S_POP1;
      S_POP1:   state_nxt = (cnt_r == CW'(1)) ? S_TOP : S_POP2;
      S_POP2:   state_nxt = S_DOWN;
      S_TOP:    state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt   = kind_r;
    node_nxt   = node_r;
    cost_nxt   = cost_r;
    mov_nxt    = mov_r;
    child_nxt  = child_r;
    pop_nxt    = pop_r;
    idx_nxt    = idx_r;
    sel_nxt    = sel_r;
    cnt_nxt    = cnt_r;
    chg_nxt    = chg_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    qcost_nxt  = qcost_r;
    hs_we = 1'b0; hs_wa = idx_r; hs_wd = mov_r;
    hs_re = 1'b0; hs_ra = '0;
    nc_we = 1'b0; nc_wa = node_r; nc_wd = cost_r;
    hp_we = 1'b0; hp_wa = mov_r.node; hp_wd = idx_r;
    pres_we = 1'b0; pres_wa = node_r; pres_wd = 1'b1;
    id_re = 1'b0;
    case (state_r)
      S_IDLE: begin
        id_re      = in_valid;
        kind_nxt   = in_kind;
        node_nxt   = in_node_id;
        cost_nxt   = in_new_cost;
        status_nxt = ST_OK;
        found_nxt  = 1'b0;
        qcost_nxt  = '0;
        pop_nxt    = '0;
        chg_nxt    = 1'b0;
      end
      S_LOOK: begin
        mov_nxt = '{node: node_r, cost: cost_r};
        case (kind_r)
          KIND_INSERT, KIND_CHANGE: begin
            if (pres && kind_r == KIND_INSERT) begin
              status_nxt = ST_PRESENT;
            end else if (pres) begin
              nc_we   = 1'b1;
              idx_nxt = hp_q;
              chg_nxt = 1'b1;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              nc_we   = 1'b1;
              pres_we = 1'b1;
              idx_nxt = IW'(cnt_r);
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          KIND_POP: begin
            if (cnt_r == '0) status_nxt = ST_EMPTY;
          end
          default: begin
            found_nxt = pres;
            qcost_nxt = pres ? nc_q : '0;
          end
        endcase
      end
      S_UP: begin
        hs_re = 1'b1;
        hs_ra = par;
      end
      S_UP_CMP: begin
        if (a_first) begin
          hs_we   = 1'b1;
          hs_wd   = hs_q;
          hp_we   = 1'b1;
          hp_wa   = hs_q.node;
          idx_nxt = par;
        end
      end
      S_DOWN: begin
        hs_re = 1'b1;
        hs_ra = IW'(lft);
      end
      S_DN_L: begin
        child_nxt = hs_q;
        sel_nxt   = IW'(lft);
        hs_re     = 1'b1;
        hs_ra     = IW'(rgt);
      end
      S_DN_R: begin
        if (a_first) begin
          child_nxt = hs_q;
          sel_nxt   = IW'(rgt);
        end
      end
      S_DN_CMP: begin
        if (a_first) begin
          hs_we   = 1'b1;
          hs_wd   = child_r;
          hp_we   = 1'b1;
          hp_wa   = child_r.node;
          idx_nxt = sel_r;
        end
      end
      S_PLACE: begin
        hs_we = 1'b1;
        hp_we = 1'b1;
      end
      S_POP0: begin
        hs_re = 1'b1;
      end
      S_POP1: begin
        pop_nxt = hs_q;
        pres_we = 1'b1;
        pres_wa = hs_q.node;
        pres_wd = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
        hs_re   = 1'b1;
        hs_ra   = IW'(cnt_r - CW'(1));
      end
      S_POP2: begin
        mov_nxt = hs_q;
        idx_nxt = '0;
      end
      S_TOP: begin
        hs_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
    if (hs_re) hs_q <= hs_mem[hs_ra];
    if (nc_we) nc_mem[nc_wa] <= nc_wd;
    if (hp_we) hp_mem[hp_wa] <= hp_wd;
    if (id_re) begin
      nc_q <= nc_mem[in_node_id];
      hp_q <= hp_mem[in_node_id];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ID_SPACE; k++) pres_r[k] <= 1'b0;
    end else if (pres_we) begin
      pres_r[pres_wa] <= pres_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    node_r   <= node_nxt;
    cost_r   <= cost_nxt;
    mov_r    <= mov_nxt;
    child_r  <= child_nxt;
    pop_r    <= pop_nxt;
    idx_r    <= idx_nxt;
    sel_r    <= sel_nxt;
    chg_r    <= chg_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    qcost_r  <= qcost_nxt;
    if (state_r == S_DONE && out_free) begin
      o_status_r <= status_r;
      o_found_r  <= found_r;
      o_qcost_r  <= qcost_r;
      o_pop_r    <= pop_r;
      o_tvalid_r <= cnt_r != '0;
      o_top_r    <= (cnt_r != '0) ? hs_q : '0;
      o_cnt_r    <= cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_found        = o_found_r;
  assign out_queried_cost = o_qcost_r;
  assign out_popped_node  = o_pop_r.node;
  assign out_popped_cost  = o_pop_r.cost;
  assign out_top_valid    = o_tvalid_r;
  assign out_top_node     = o_top_r.node;
  assign out_top_cost     = o_top_r.cost;
  assign out_entry_count  = o_cnt_r;

endmodule

FILE: hdl/ihq_chk.sv
// ihq_chk: port-level checks for indexed_min_heap_queue, bound to the top level
// depends on ihq_pkg
module ihq_chk
  import ihq_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic [1:0]    in_kind,
  input logic [7:0]    in_node_id,
  input logic [31:0]   in_new_cost,
  input logic          out_valid,
  input logic          out_ready,
  input logic [1:0]    out_status,
  input logic          out_found,
  input logic [31:0]   out_queried_cost,
  input logic [7:0]    out_popped_node,
  input logic [31:0]   out_popped_cost,
  input logic          out_top_valid,
  input logic [7:0]    out_top_node,
  input logic [31:0]   out_top_cost,
  input logic [CW-1:0] out_entry_count
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(MAX_NODES))
    else $error("entry count out of range");

  a_top_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_top_valid == (out_entry_count != '0))
    else $error("top valid disagrees with entry count");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_popped_node == '0 && out_popped_cost == '0 && out_entry_count == '0)
    else $error("empty pop reports an entry");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_top_cost))
    else $error("stalled result changed");

endmodule

bind indexed_min_heap_queue ihq_chk #(.MAX_NODES(MAX_NODES)) u_ihq_chk (.*);
